// File: design/cesd_pkg.sv
// ----------------------------------------------------------------------------
// cesd_pkg: shared types and constants for the C-style escape decoder
// Decode states, control code lookup and result buffer sizing.
// ----------------------------------------------------------------------------
package cesd_pkg;

    localparam int unsigned ByteW     = 8;
    localparam int unsigned BufDepth  = 4;
    localparam int unsigned BufPtrW   = $clog2(BufDepth);
    localparam int unsigned BufCntW   = $clog2(BufDepth + 1);

    localparam logic [ByteW-1:0] BACKSLASH = 8'h5C;

    // Decode state, one-hot
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_ESCAPE = 3'b010,
        MODE_OCTAL  = 3'b100
    } mode_t;

    // One decoded byte with its end-of-run flag
    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             last;
    } result_t;

    function automatic logic is_octal_digit(input logic [ByteW-1:0] b);
        return (b >= 8'h30) && (b <= 8'h37);
    endfunction

    // Letter after a backslash mapped to its control code
    function automatic logic [ByteW-1:0] control_code(input logic [ByteW-1:0] b);
        logic [ByteW-1:0] code;
        unique case (b)
            8'h61:   code = 8'h07; // a
            8'h62:   code = 8'h08; // b
            8'h66:   code = 8'h0C; // f
            8'h6E:   code = 8'h0A; // n
            8'h72:   code = 8'h0D; // r
            8'h74:   code = 8'h09; // t
            8'h76:   code = 8'h0B; // v
            default: code = b;
        endcase
        return code;
    endfunction

endpackage

// File: design/c_style_escape_decoder_unit.sv
// ----------------------------------------------------------------------------
// c_style_escape_decoder_unit: streaming C-style backslash escape decoder
// Decodes one byte per transfer into zero, one or two output bytes.
// ----------------------------------------------------------------------------
// Takes one byte per clock. Each accepted byte is decoded in the same cycle
// against the escape state and its zero, one or two result bytes land in a
// four-entry result buffer, which drains one byte per cycle while m_tready
// is high. s_tready is high while the buffer has room for two more results,
// so one byte per cycle is sustained as long as each byte yields at most
// one result; a byte that yields two (an octal run ended by a non-digit
// other than a backslash) adds a byte that the buffer absorbs. Results
// appear on m_* in the cycle after the input transfer at the earliest.
// s_tlast ends a string: a pending octal value is flushed, a lone trailing
// backslash is dropped, and m_tlast marks the last result of each input.
module c_style_escape_decoder_unit
    import cesd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // input stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [ByteW-1:0] s_tdata,   // [7:0] in_byte
    input  logic             s_tlast,   // is_last
    // output stream
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [ByteW-1:0] m_tdata,   // [7:0] out_byte
    output logic             m_tlast    // last_of_run
);

    // decode state
    mode_t            mode_reg, mode_next;
    logic [ByteW-1:0] oct_val_reg, oct_val_next;
    logic [1:0]       oct_cnt_reg, oct_cnt_next;

    // result buffer
    result_t          buf_mem [BufDepth];
    logic [BufPtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [BufCntW-1:0] count_reg;
    logic [BufCntW-1:0] n_push;

    logic       in_xfer, out_xfer;
    logic [1:0] n_res;
    result_t    res0, res1;

    assign s_tready = (count_reg <= BufCntW'(BufDepth - 2));
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign out_xfer = m_tvalid && m_tready;
    assign m_tdata  = buf_mem[rd_ptr_reg].data;
    assign m_tlast  = buf_mem[rd_ptr_reg].last;
    assign n_push   = in_xfer ? BufCntW'(n_res) : '0;

    // single-pass decode of the incoming byte
    always_comb
    begin
        logic [ByteW-1:0] b;
        logic [ByteW-1:0] r0_byte, r1_byte;
        logic             handle_normal;
        b             = s_tdata;
        mode_next     = mode_reg;
        oct_val_next  = oct_val_reg;
        oct_cnt_next  = oct_cnt_reg;
        n_res         = 2'd0;
        r0_byte       = '0;
        r1_byte       = '0;
        handle_normal = 1'b0;

        unique case (mode_reg)
            MODE_ESCAPE:
            begin
                if (is_octal_digit(b))
                begin
                    oct_val_next = {5'b0, b[2:0]};
                    oct_cnt_next = 2'd1;
                    mode_next    = MODE_OCTAL;
                end
                else
                begin
                    mode_next = MODE_NORMAL;
                    r0_byte   = control_code(b);
                    n_res     = 2'd1;
                end
            end
            MODE_OCTAL:
            begin
                if (is_octal_digit(b) && (oct_cnt_reg != 2'd3))
                begin
                    oct_val_next = {oct_val_reg[4:0], b[2:0]};
                    oct_cnt_next = oct_cnt_reg + 2'd1;
                    if (oct_cnt_reg == 2'd2)
                    begin
                        r0_byte      = oct_val_next;
                        n_res        = 2'd1;
                        mode_next    = MODE_NORMAL;
                        oct_val_next = '0;
                        oct_cnt_next = 2'd0;
                    end
                end
                else
                begin
                    // release the pending value, then treat the byte as plain
                    r0_byte       = oct_val_reg;
                    n_res         = 2'd1;
                    oct_val_next  = '0;
                    oct_cnt_next  = 2'd0;
                    handle_normal = 1'b1;
                end
            end
            default:
            begin
                handle_normal = 1'b1;
            end
        endcase

        if (handle_normal)
        begin
            if (b == BACKSLASH)
            begin
                mode_next = MODE_ESCAPE;
            end
            else
            begin
                mode_next = MODE_NORMAL;
                if (n_res == 2'd0)
                begin
                    r0_byte = b;
                    n_res   = 2'd1;
                end
                else
                begin
                    r1_byte = b;
                    n_res   = 2'd2;
                end
            end
        end

        // end of string: flush octal, drop a lone backslash
        if (s_tlast)
        begin
            if (mode_next == MODE_OCTAL)
            begin
                if (n_res == 2'd0)
                begin
                    r0_byte = oct_val_next;
                    n_res   = 2'd1;
                end
                else
                begin
                    r1_byte = oct_val_next;
                    n_res   = 2'd2;
                end
            end
            mode_next    = MODE_NORMAL;
            oct_val_next = '0;
            oct_cnt_next = 2'd0;
        end

        res0.data = r0_byte;
        res0.last = (n_res == 2'd1);
        res1.data = r1_byte;
        res1.last = 1'b1;
    end

    // decode state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NORMAL;
            oct_val_reg <= '0;
            oct_cnt_reg <= '0;
        end
        else if (in_xfer)
        begin
            mode_reg    <= mode_next;
            oct_val_reg <= oct_val_next;
            oct_cnt_reg <= oct_cnt_next;
        end
    end

    // result buffer pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + n_push[BufPtrW-1:0];
            if (out_xfer)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + n_push - BufCntW'(out_xfer);
        end
    end

    // result buffer storage
    always_ff @(posedge clk)
    begin
        if (in_xfer && (n_res != 2'd0))
        begin
            buf_mem[wr_ptr_reg] <= res0;
        end
        if (in_xfer && (n_res == 2'd2))
        begin
            buf_mem[wr_ptr_reg + 1'b1] <= res1;
        end
    end

endmodule
